// File: src/lihtd_pkg.sv
// Shared types and command codes for the ordered-list block.
// Depends on nothing; imported by lihtd_mem and the top level.
package lihtd_pkg;

	localparam int WordW = 32;

	typedef logic signed [WordW-1:0] word_t;

	// Command codes carried on the operation port
	localparam logic [1:0] OP_FRONT  = 2'd0;
	localparam logic [1:0] OP_BACK   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

endpackage

// File: src/lihtd_mem.sv
// Element store: one write port, one read port with registered read data.
// Depends on lihtd_pkg for the word type.
module lihtd_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  lihtd_pkg::word_t wdata,
	input  logic [AW-1:0]    raddr,
	output lihtd_pkg::word_t rdata
);
	import lihtd_pkg::*;

	word_t mem_q [DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/list_insert_head_tail_delete_at.sv
// Top level of the ordered list of signed 32-bit words.
// Depends on lihtd_pkg and lihtd_mem.
//
// Usage:
//   Issue a command by raising start with operation and operand while busy is
//   low; the word is taken at that clock edge. Operation 0 inserts operand at
//   the front, 1 appends it at the back, 2 removes the element at position
//   operand (a negative or out-of-range position leaves the list as it is).
//   After every command the whole list is listed front to back: one result per
//   element, each on element_value for exactly one cycle with strobe high, and
//   is_last high on the final one. An empty list gives a single result with
//   list_empty and is_last high and element_value zero. An insert into a full
//   list is dropped and insert_dropped is high on every result of that command.
//   The receiver cannot stall; results must be taken as they come.
// Sequence:
//   The command is decoded after the accepting edge. A removal moves each word
//   behind the removed slot down one slot; a front insert moves every word up
//   one slot, last first, then writes the new word at the front. Then one
//   listing cycle per result follows, each result showing in the cycle after
//   its listing cycle. Busy falls in the cycle of the final result, so the next
//   word can be taken at its end. Front inserts into CAPACITY-1 hold busy longest.
// Reset:
//   arst_n empties the list at once; stored words need no clearing because only
//   entries below the element count are ever used.
module list_insert_head_tail_delete_at #(
	parameter int CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       operation,
	input  lihtd_pkg::word_t operand,
	output logic             busy,
	output logic             strobe,
	output lihtd_pkg::word_t element_value,
	output logic             is_last,
	output logic             list_empty,
	output logic             insert_dropped
);
	import lihtd_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_FIX,
		S_LIST
	} state_t;

	state_t        state_q;
	logic [1:0]    op_q;
	word_t         operand_q;
	logic [CW-1:0] count_q;
	logic          up_q;
	logic [IW-1:0] src_q;
	logic [IW-1:0] last_src_q;
	logic [CW-1:0] rem_q;
	logic          pend_q;
	logic [IW-1:0] li_q;
	logic          dropped_q;
	logic          strobe_q;
	logic          last_q;
	logic          empty_q;

	// memory port signals
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	word_t         mem_wdata;
	logic [IW-1:0] mem_raddr;
	word_t         mem_rdata;

	// removal position decode
	logic          pos_ok;
	logic [IW-1:0] pos;
	logic          list_done;

	assign pos    = operand_q[IW-1:0];
	assign pos_ok = !operand_q[WordW-1]
		&& ({1'b0, operand_q[WordW-2:0]} < 32'(count_q));
	assign list_done = (CW'(li_q) == count_q - CW'(1));

	lihtd_mem #(
		.DEPTH(CAPACITY),
		.AW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Drive the memory ports from the sequencer state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = operand_q;
		mem_raddr = '0;
		unique case (state_q)
			S_EXEC: begin
				// append: write straight behind the last element
				if (op_q == OP_BACK && count_q < CAP_C) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[IW-1:0];
				end
			end
			S_SHIFT: begin
				// write back the word read last cycle one slot over
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = up_q ? last_src_q + IW'(1) : last_src_q - IW'(1);
					mem_wdata = mem_rdata;
				end
				mem_raddr = src_q;
			end
			S_FIX: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
			end
			S_LIST: begin
				mem_raddr = li_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and registered result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= '0;
			operand_q  <= '0;
			count_q    <= '0;
			up_q       <= 1'b0;
			src_q      <= '0;
			last_src_q <= '0;
			rem_q      <= '0;
			pend_q     <= 1'b0;
			li_q       <= '0;
			dropped_q  <= 1'b0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
			empty_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= operation;
						operand_q <= operand;
						dropped_q <= 1'b0;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					li_q   <= '0;
					pend_q <= 1'b0;
					unique case (op_q) inside
						OP_FRONT, OP_BACK: begin
							if (count_q >= CAP_C) begin
								// full: drop the word, list unchanged
								dropped_q <= 1'b1;
								state_q   <= S_LIST;
							end else if (op_q == OP_BACK) begin
								count_q <= count_q + CW'(1);
								state_q <= S_LIST;
							end else begin
								// move every element up one slot, last first
								up_q    <= 1'b1;
								src_q   <= count_q[IW-1:0] - IW'(1);
								rem_q   <= count_q;
								state_q <= S_SHIFT;
							end
						end
						OP_REMOVE: begin
							if (pos_ok) begin
								// move the tail down over the removed slot
								up_q    <= 1'b0;
								src_q   <= pos + IW'(1);
								rem_q   <= count_q - CW'(1) - CW'(pos);
								state_q <= S_SHIFT;
							end else begin
								state_q <= S_LIST;
							end
						end
						default: begin
							state_q <= S_LIST;
						end
					endcase
				end
				S_SHIFT: begin
					pend_q <= (rem_q != '0);
					if (rem_q != '0) begin
						last_src_q <= src_q;
						src_q      <= up_q ? src_q - IW'(1) : src_q + IW'(1);
						rem_q      <= rem_q - CW'(1);
					end else if (up_q) begin
						state_q <= S_FIX;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_LIST;
					end
				end
				S_FIX: begin
					count_q <= count_q + CW'(1);
					state_q <= S_LIST;
				end
				S_LIST: begin
					strobe_q <= 1'b1;
					if (count_q == '0) begin
						last_q  <= 1'b1;
						empty_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						empty_q <= 1'b0;
						last_q  <= list_done;
						li_q    <= li_q + IW'(1);
						if (list_done) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign strobe         = strobe_q;
	assign element_value  = empty_q ? '0 : mem_rdata;
	assign is_last        = last_q;
	assign list_empty     = empty_q;
	assign insert_dropped = dropped_q;

endmodule
